// File: hdl/filtered_device_registry_unit_macros.svh
// Assertion macros shared by the filtered device registry RTL.
`ifndef FILTERED_DEVICE_REGISTRY_UNIT_MACROS_SVH
`define FILTERED_DEVICE_REGISTRY_UNIT_MACROS_SVH
`ifndef SYNTH
// Checks a property on every clock edge outside reset.
`define FDR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Checks that a condition is followed by a consequence in the next cycle.
`define FDR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define FDR_ASSERT(lbl, prop, msg)
`define FDR_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// File: hdl/fdr_pkg.sv
// Types, constants and codes of the filtered device registry.
`default_nettype none
package fdr_pkg;

  localparam int unsigned TableDepth = 32;
  localparam int unsigned OwnerBits  = 16;
  localparam int unsigned IdxW       = $clog2(TableDepth);
  localparam int unsigned CntW       = $clog2(TableDepth + 1);

  typedef logic [IdxW-1:0]      idx_t;
  typedef logic [CntW-1:0]      cnt_t;
  typedef logic [OwnerBits-1:0] owner_t;

  // Operation codes.
  localparam logic [2:0] OpAdd     = 3'd0;
  localparam logic [2:0] OpCount   = 3'd1;
  localparam logic [2:0] OpGetNth  = 3'd2;
  localparam logic [2:0] OpReserve = 3'd3;
  localparam logic [2:0] OpRelease = 3'd4;

  // Filter register indexes.
  localparam logic [2:0] RegVendor    = 3'd0;
  localparam logic [2:0] RegDevice    = 3'd1;
  localparam logic [2:0] RegBaseClass = 3'd2;
  localparam logic [2:0] RegSubClass  = 3'd3;
  localparam logic [2:0] RegProgIf    = 3'd4;

  typedef enum logic [2:0] {
    StOk          = 3'd0,
    StNoDevice    = 3'd1,
    StInUse       = 3'd2,
    StNotInUse    = 3'd3,
    StTableFull   = 3'd4,
    StBadCmd      = 3'd5,
    StNoRequester = 3'd6
  } status_e;

  typedef struct packed {
    logic [2:0]  operation;
    logic [15:0] new_vendor;
    logic [15:0] new_device;
    logic [7:0]  new_base_class;
    logic [7:0]  new_sub_class;
    logic [7:0]  new_prog_if;
    logic [31:0] match_number;
    logic [15:0] requester_id;
  } cmd_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [5:0]  match_count;
    logic [4:0]  slot_index;
    logic [15:0] entry_vendor;
    logic [15:0] entry_device;
    logic [7:0]  entry_base_class;
    logic [7:0]  entry_sub_class;
    logic [7:0]  entry_prog_if;
    logic [15:0] entry_owner;
    logic        granted;
  } rsp_t;

  typedef struct packed {
    logic [2:0]  index;
    logic [16:0] value;
  } cfg_t;

  typedef struct packed {
    logic [15:0] vendor;
    logic [15:0] device;
    logic [7:0]  base_class;
    logic [7:0]  sub_class;
    logic [7:0]  prog_if;
    owner_t      owner;
  } entry_t;

  // Access request from the sequencer to the entry table.
  typedef struct packed {
    logic   we;
    idx_t   waddr;
    entry_t wdata;
    logic   re;
    idx_t   raddr;
  } tbl_req_t;

endpackage
`default_nettype wire

// File: hdl/fdr_intf.sv
// Handshake channel interfaces of the filtered device registry.
`default_nettype none
interface fdr_cmd_if;
  logic         valid;
  logic         ready;
  fdr_pkg::cmd_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface fdr_rsp_if;
  logic         valid;
  logic         ready;
  fdr_pkg::rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface fdr_cfg_if;
  logic         valid;
  logic         ready;
  fdr_pkg::cfg_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: hdl/fdr_filter.sv
// Filter registers and the shared entry compare unit.
`default_nettype none
module fdr_filter (
  input  logic             clk_i,
  input  logic             rst_ni,
  fdr_cfg_if.sink          cfg_i,
  input  fdr_pkg::entry_t  entry_i,
  output logic             match_o
);

  logic [16:0] vendor_q, device_q;
  logic [8:0]  base_q, sub_q, prog_q;

  // A key of all ones is the wildcard; any other negative key matches nothing.
  function automatic logic key16_ok(input logic [16:0] key, input logic [15:0] val);
    return (&key) || (!key[16] && (key[15:0] == val));
  endfunction

  function automatic logic key8_ok(input logic [8:0] key, input logic [7:0] val);
    return (&key) || (!key[8] && (key[7:0] == val));
  endfunction

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vendor_q <= '1;
      device_q <= '1;
      base_q   <= '1;
      sub_q    <= '1;
      prog_q   <= '1;
    end else if (cfg_i.valid) begin
      case (cfg_i.data.index)
        fdr_pkg::RegVendor:    vendor_q <= cfg_i.data.value;
        fdr_pkg::RegDevice:    device_q <= cfg_i.data.value;
        fdr_pkg::RegBaseClass: base_q   <= cfg_i.data.value[8:0];
        fdr_pkg::RegSubClass:  sub_q    <= cfg_i.data.value[8:0];
        fdr_pkg::RegProgIf:    prog_q   <= cfg_i.data.value[8:0];
        default: ;
      endcase
    end
  end

  assign match_o = key16_ok(vendor_q, entry_i.vendor)
                && key16_ok(device_q, entry_i.device)
                && key8_ok(base_q, entry_i.base_class)
                && key8_ok(sub_q, entry_i.sub_class)
                && key8_ok(prog_q, entry_i.prog_if);

endmodule
`default_nettype wire

// File: hdl/fdr_table.sv
// Entry table memory with one write port and one registered read port.
`default_nettype none
module fdr_table (
  input  logic              clk_i,
  input  fdr_pkg::tbl_req_t req_i,
  output fdr_pkg::entry_t   rdata_o
);

  fdr_pkg::entry_t mem [fdr_pkg::TableDepth];
  fdr_pkg::entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// File: hdl/fdr_ctrl.sv
// Sequencer: command decode, table scan, ownership update and result register.
`default_nettype none
`include "filtered_device_registry_unit_macros.svh"
module fdr_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  fdr_cmd_if.sink            cmd_i,
  fdr_rsp_if.source          rsp_o,
  output fdr_pkg::tbl_req_t  tbl_req_o,
  input  fdr_pkg::entry_t    tbl_rdata_i,
  input  logic               match_i
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_OWN  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]       state_q, state_d;
  fdr_pkg::cnt_t    count_q, count_d;
  fdr_pkg::cnt_t    addr_q, addr_d;
  fdr_pkg::cnt_t    hits_q, hits_d;
  logic             rd_vld_q, rd_vld_d;
  fdr_pkg::idx_t    rd_slot_q, rd_slot_d;
  fdr_pkg::idx_t    slot_q, slot_d;
  fdr_pkg::entry_t  ent_q, ent_d;
  fdr_pkg::cmd_t    cmd_q, cmd_d;
  fdr_pkg::rsp_t    res_q, res_d;
  fdr_pkg::rsp_t    rsp_q, rsp_d;
  logic             rsp_valid_q, rsp_valid_d;
  logic             issue;
  logic             rank_hit;
  fdr_pkg::owner_t  req_owner;
  fdr_pkg::owner_t  owner_new;

  assign req_owner = cmd_q.requester_id[fdr_pkg::OwnerBits-1:0];
  assign issue     = (addr_q < count_q);
  assign rank_hit  = (cmd_q.match_number[31:fdr_pkg::CntW] == '0)
                  && (hits_q == cmd_q.match_number[fdr_pkg::CntW-1:0]);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    addr_d      = addr_q;
    hits_d      = hits_q;
    rd_vld_d    = 1'b0;
    rd_slot_d   = rd_slot_q;
    slot_d      = slot_q;
    ent_d       = ent_q;
    cmd_d       = cmd_q;
    res_d       = res_q;
    rsp_d       = rsp_q;
    rsp_valid_d = rsp_valid_q && !rsp_o.ready;
    owner_new   = ent_q.owner;
    tbl_req_o       = '0;
    tbl_req_o.raddr = addr_q[fdr_pkg::IdxW-1:0];
    tbl_req_o.waddr = slot_q;
    tbl_req_o.wdata = ent_q;

    case (state_q)
      S_IDLE: begin
        if (cmd_i.valid) begin
          cmd_d   = cmd_i.data;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        res_d  = '0;
        addr_d = '0;
        hits_d = '0;
        case (cmd_q.operation)
          fdr_pkg::OpAdd: begin
            if (count_q == fdr_pkg::cnt_t'(fdr_pkg::TableDepth)) begin
              res_d.status = fdr_pkg::StTableFull;
            end else begin
              tbl_req_o.we               = 1'b1;
              tbl_req_o.waddr            = count_q[fdr_pkg::IdxW-1:0];
              tbl_req_o.wdata.vendor     = cmd_q.new_vendor;
              tbl_req_o.wdata.device     = cmd_q.new_device;
              tbl_req_o.wdata.base_class = cmd_q.new_base_class;
              tbl_req_o.wdata.sub_class  = cmd_q.new_sub_class;
              tbl_req_o.wdata.prog_if    = cmd_q.new_prog_if;
              tbl_req_o.wdata.owner      = '0;
              res_d.slot_index           = count_q[fdr_pkg::IdxW-1:0];
              res_d.entry_vendor         = cmd_q.new_vendor;
              res_d.entry_device         = cmd_q.new_device;
              res_d.entry_base_class     = cmd_q.new_base_class;
              res_d.entry_sub_class      = cmd_q.new_sub_class;
              res_d.entry_prog_if        = cmd_q.new_prog_if;
              count_d                    = count_q + fdr_pkg::cnt_t'(1);
            end
            state_d = S_DONE;
          end
          fdr_pkg::OpCount, fdr_pkg::OpGetNth, fdr_pkg::OpReserve,
          fdr_pkg::OpRelease: begin
            state_d = S_SCAN;
          end
          default: begin
            res_d.status = fdr_pkg::StBadCmd;
            state_d      = S_DONE;
          end
        endcase
      end
      S_SCAN: begin
        // One slot read is issued per cycle; its match is judged in the cycle after.
        if (issue) begin
          tbl_req_o.re = 1'b1;
          addr_d       = addr_q + fdr_pkg::cnt_t'(1);
        end
        rd_vld_d  = issue;
        rd_slot_d = addr_q[fdr_pkg::IdxW-1:0];
        if (rd_vld_q && match_i) begin
          if ((cmd_q.operation != fdr_pkg::OpCount) && rank_hit) begin
            ent_d    = tbl_rdata_i;
            slot_d   = rd_slot_q;
            rd_vld_d = 1'b0;
            state_d  = S_OWN;
          end else begin
            hits_d = hits_q + fdr_pkg::cnt_t'(1);
          end
        end
        if (!issue && !rd_vld_q) begin
          if (cmd_q.operation == fdr_pkg::OpCount) begin
            res_d.match_count = hits_q;
          end else begin
            res_d.status = fdr_pkg::StNoDevice;
          end
          state_d = S_DONE;
        end
      end
      S_OWN: begin
        case (cmd_q.operation)
          fdr_pkg::OpReserve: begin
            if (ent_q.owner != '0) begin
              res_d.status = fdr_pkg::StInUse;
            end else if (req_owner == '0) begin
              res_d.status = fdr_pkg::StNoRequester;
            end else begin
              owner_new     = req_owner;
              res_d.granted = 1'b1;
            end
          end
          fdr_pkg::OpRelease: begin
            if (ent_q.owner == '0) begin
              res_d.status = fdr_pkg::StNotInUse;
            end else if (req_owner == '0) begin
              res_d.status = fdr_pkg::StNoRequester;
            end else if (ent_q.owner != req_owner) begin
              res_d.status = fdr_pkg::StNotInUse;
            end else begin
              owner_new     = '0;
              res_d.granted = 1'b1;
            end
          end
          default: ;
        endcase
        tbl_req_o.we          = res_d.granted;
        tbl_req_o.wdata.owner = owner_new;
        res_d.slot_index       = slot_q;
        res_d.entry_vendor     = ent_q.vendor;
        res_d.entry_device     = ent_q.device;
        res_d.entry_base_class = ent_q.base_class;
        res_d.entry_sub_class  = ent_q.sub_class;
        res_d.entry_prog_if    = ent_q.prog_if;
        res_d.entry_owner      = owner_new;
        state_d                = S_DONE;
      end
      S_DONE: begin
        if (!rsp_valid_q || rsp_o.ready) begin
          rsp_d       = res_q;
          rsp_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      rd_vld_q    <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rd_vld_q    <= rd_vld_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q    <= addr_d;
    hits_q    <= hits_d;
    rd_slot_q <= rd_slot_d;
    slot_q    <= slot_d;
    ent_q     <= ent_d;
    cmd_q     <= cmd_d;
    res_q     <= res_d;
    rsp_q     <= rsp_d;
  end

  assign cmd_i.ready = (state_q == S_IDLE);
  assign rsp_o.valid = rsp_valid_q;
  assign rsp_o.data  = rsp_q;

  `FDR_ASSERT(a_count_bound, count_q <= fdr_pkg::cnt_t'(fdr_pkg::TableDepth), "entry count overflow")
  `FDR_ASSERT(a_write_state, !tbl_req_o.we || state_q == S_EXEC || state_q == S_OWN, "table write outside update")
  `FDR_ASSERT(a_rsp_from_done, !$rose(rsp_valid_q) || $past(state_q) == S_DONE, "result without completion")
  `FDR_ASSERT(a_grant_ok, !(rsp_valid_q && rsp_q.granted) || rsp_q.status == fdr_pkg::StOk, "grant with error status")
  `FDR_ASSERT_NEXT(a_add_count, state_q == S_EXEC && tbl_req_o.we, count_q == $past(count_q) + fdr_pkg::cnt_t'(1), "add did not advance count")

endmodule
`default_nettype wire

// File: hdl/filtered_device_registry_unit.sv
// Top level of the filtered device registry.
//
//   channel   dir   word      accepted when
//   cmd_i     in    cmd_t     cmd_i.valid && cmd_i.ready
//   rsp_o     out   rsp_t     rsp_o.valid && rsp_o.ready
//   cfg_i     in    cfg_t     cfg_i.valid && cfg_i.ready (always ready)
//
// An add or a rejected command goes from decode straight to its result word.
// Count, fetch, reserve and release scan one slot per cycle through the single read
// port of the entry memory before their word is built; the sequencer is back in idle
// and ready for the next command in the same cycle that the word becomes valid.
// Reset clears the entry count and sets every filter key to the wildcard; the entry memory is not cleared.
// A command only stalls at its end while the previous result word has not been taken.
`default_nettype none
module filtered_device_registry_unit (
  input  logic      clk_i,
  input  logic      rst_ni,
  fdr_cmd_if.sink   cmd_i,
  fdr_rsp_if.source rsp_o,
  fdr_cfg_if.sink   cfg_i
);

  // Request bundle from the sequencer into the table.
  fdr_pkg::tbl_req_t tbl_req;
  // Registered read word of the table, which also feeds the filter compare unit.
  fdr_pkg::entry_t   tbl_rdata;
  // Result of comparing the read word against the five filter keys.
  logic              match;

  // Filter registers live next to the compare logic they drive.
  fdr_filter u_filter (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_i),
    .entry_i (tbl_rdata),
    .match_o (match)
  );

  // Vendor, device, class codes and owner per slot in one memory row.
  fdr_table u_table (
    .clk_i   (clk_i),
    .req_i   (tbl_req),
    .rdata_o (tbl_rdata)
  );

  // The sequencer decodes a command, runs the scan and builds the result word.
  fdr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_i),
    .rsp_o       (rsp_o),
    .tbl_req_o   (tbl_req),
    .tbl_rdata_i (tbl_rdata),
    .match_i     (match)
  );

endmodule
`default_nettype wire
